// ===== src/rrbb_pkg.sv =====
// rrbb_pkg: types and constants shared by the rtcp report block builder
// no dependencies; used by every module under src

package rrbb_pkg;

    // default number of per-source history slots
    localparam int MAX_SOURCES_DEF = 16;

    // field widths of the report block
    localparam int FRAC_W  = 8;
    localparam int CUM_W   = 24;
    localparam int JIT_W   = 28;
    localparam int WORD_W  = 32;
    localparam int SEQ_W   = 16;

    // delay since last sr is scaled by this factor
    localparam logic [6:0] DELAY_SCALE = 7'd65;

    // saturated loss fraction
    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    // input item: one source's receive statistics
    typedef struct packed {
        logic [3:0]        source_index;
        logic              skip_source;
        logic [WORD_W-1:0] source_ssrc;
        logic [SEQ_W-1:0]  seq_cycles;
        logic [SEQ_W-1:0]  highest_seq;
        logic [WORD_W-1:0] base_seq;
        logic [WORD_W-1:0] packets_received;
        logic [WORD_W-1:0] jitter_raw;
        logic [WORD_W-1:0] last_sr_stamp;
        logic [WORD_W-1:0] now_ms;
        logic [WORD_W-1:0] sr_arrival_ms;
    } in_item_t;

    // result item: one report block
    typedef struct packed {
        logic [WORD_W-1:0] report_ssrc;
        logic [FRAC_W-1:0] fraction_lost;
        logic [CUM_W-1:0]  cumulative_lost;
        logic [SEQ_W-1:0]  cycles_out;
        logic [SEQ_W-1:0]  highest_seq_out;
        logic [JIT_W-1:0]  jitter_out;
        logic [WORD_W-1:0] last_sr_out;
        logic [WORD_W-1:0] sr_delay;
    } out_item_t;

    // status of the loss fraction divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/rrbb_history.sv =====
// rrbb_history: per-source table of expected and received counts at last report
// depends on rrbb_pkg; one write port, one registered read port, valid bits per slot

module rrbb_history #(
    parameter int MAX_SOURCES = rrbb_pkg::MAX_SOURCES_DEF,
    parameter int IDX_W       = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [rrbb_pkg::WORD_W-1:0] rd_expected,
    output logic [rrbb_pkg::WORD_W-1:0] rd_received,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [rrbb_pkg::WORD_W-1:0] wr_expected,
    input  logic [rrbb_pkg::WORD_W-1:0] wr_received
);

    localparam int ENTRY_W = 2 * rrbb_pkg::WORD_W;

    logic [ENTRY_W-1:0]     mem [MAX_SOURCES];
    logic [MAX_SOURCES-1:0] valid_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_valid_reg;

    // valid bits: a slot never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_expected, wr_received};
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_expected = rd_valid_reg ? rd_data_reg[ENTRY_W-1:rrbb_pkg::WORD_W] : '0;
    assign rd_received = rd_valid_reg ? rd_data_reg[rrbb_pkg::WORD_W-1:0] : '0;

endmodule

// ===== src/rrbb_frac_div.sv =====
// rrbb_frac_div: iterative divider giving floor(lost * 256 / expected), saturated
// depends on rrbb_pkg; one shift-subtract step per cycle

module rrbb_frac_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rrbb_pkg::WORD_W-1:0]   dividend,
    input  logic [rrbb_pkg::WORD_W-1:0]   divisor,
    output rrbb_pkg::div_status_t         status,
    output logic [rrbb_pkg::FRAC_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(rrbb_pkg::FRAC_W + 1);

    logic [rrbb_pkg::WORD_W-1:0] rem_reg;
    logic [rrbb_pkg::WORD_W-1:0] divisor_reg;
    logic [rrbb_pkg::FRAC_W-1:0] quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [rrbb_pkg::WORD_W:0]   shifted;
    logic [rrbb_pkg::WORD_W:0]   diff;
    logic                        fits;

    // shared shift, compare and subtract step
    always_comb begin
        shifted = {rem_reg, 1'b0};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    // control: count the quotient bits, pulse done on the last one or on a saturating start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (dividend >= divisor) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(rrbb_pkg::FRAC_W);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= divisor;
            rem_reg     <= dividend;
            quot_reg    <= (dividend >= divisor) ? rrbb_pkg::FRAC_MAX : '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[rrbb_pkg::WORD_W-1:0] : shifted[rrbb_pkg::WORD_W-1:0];
            quot_reg <= {quot_reg[rrbb_pkg::FRAC_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule

// ===== src/rtcp_report_block_builder.sv =====
// Builds one RTCP receiver report block per source item. An item is taken only
// while the block is idle; a skipped source is taken and gives no result. Any
// other item passes from acceptance through the states ST_EXPN and ST_INTV (count
// arithmetic and history update) and ST_LOSS, then through the loss fraction
// divider, which produces one quotient bit per cycle for eight bits and then
// signals done (without iterating when the fraction saturates; the divider is
// skipped when the interval shows no loss), then ST_DONE, where the report block
// is loaded into the output register once a full output register has drained.
// The next item is accepted the cycle after the load. A finished block waits in
// the output register while the next item is accepted. History slots read as
// zero after reset.
// depends on rrbb_pkg, rrbb_history, rrbb_frac_div

module rtcp_report_block_builder #(
    parameter int MAX_SOURCES = rrbb_pkg::MAX_SOURCES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrbb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rrbb_pkg::out_item_t m_data
);

    localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int SRC_N  = 16;
    localparam int WORD_W = rrbb_pkg::WORD_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXPN = 6'b000010,
        ST_INTV = 6'b000100,
        ST_LOSS = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    rrbb_pkg::in_item_t  item_reg;
    rrbb_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;
    logic [IDX_W-1:0]    slot_reg;

    logic [WORD_W-1:0]            expected_reg;
    logic [WORD_W-1:0]            elapsed_reg;
    logic                         delay_ok_reg;
    logic [WORD_W-1:0]            delay_reg;
    logic [WORD_W-1:0]            exp_int_reg;
    logic [WORD_W-1:0]            rcv_int_reg;
    logic [rrbb_pkg::CUM_W-1:0]   cum_reg;
    logic [rrbb_pkg::FRAC_W-1:0]  frac_reg;

    logic [IDX_W-1:0]     slot_lut [SRC_N];
    logic                 accept;
    logic                 out_free;
    logic [WORD_W-1:0]    prior_expected;
    logic [WORD_W-1:0]    prior_received;
    logic [WORD_W-1:0]    lost_bits;
    logic                 lost_none;
    logic                 div_start;
    rrbb_pkg::div_status_t div_status;
    logic [rrbb_pkg::FRAC_W-1:0] div_quot;

    // source index to slot, folded by the table size
    for (genvar i = 0; i < SRC_N; i++) begin : g_slot
        assign slot_lut[i] = IDX_W'(i % MAX_SOURCES);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // interval loss and the not-positive check
    assign lost_bits = exp_int_reg - rcv_int_reg;
    assign lost_none = (exp_int_reg == '0) || (lost_bits == '0) || lost_bits[WORD_W-1];
    assign div_start = (state_reg == ST_LOSS) && !lost_none;

    rrbb_history #(
        .MAX_SOURCES (MAX_SOURCES),
        .IDX_W       (IDX_W)
    ) u_history (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (accept && !s_data.skip_source),
        .rd_addr     (slot_lut[s_data.source_index]),
        .rd_expected (prior_expected),
        .rd_received (prior_received),
        .wr_en       (state_reg == ST_INTV),
        .wr_addr     (slot_reg),
        .wr_expected (expected_reg),
        .wr_received (item_reg.packets_received)
    );

    rrbb_frac_div u_frac_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lost_bits),
        .divisor  (exp_int_reg),
        .status   (div_status),
        .quotient (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_data.skip_source) begin
                    state_next = ST_EXPN;
                end
            end
            ST_EXPN: state_next = ST_INTV;
            ST_INTV: state_next = ST_LOSS;
            ST_LOSS: state_next = lost_none ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers, one step of arithmetic per state
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            slot_reg <= slot_lut[s_data.source_index];
        end
        if (state_reg == ST_EXPN) begin
            expected_reg <= {item_reg.seq_cycles, item_reg.highest_seq}
                            - item_reg.base_seq + WORD_W'(1);
            elapsed_reg  <= item_reg.now_ms - item_reg.sr_arrival_ms;
            delay_ok_reg <= (item_reg.last_sr_stamp != '0)
                            && (item_reg.now_ms > item_reg.sr_arrival_ms);
        end
        if (state_reg == ST_INTV) begin
            exp_int_reg <= expected_reg - prior_expected;
            rcv_int_reg <= item_reg.packets_received - prior_received;
            cum_reg     <= rrbb_pkg::CUM_W'(expected_reg - item_reg.packets_received);
            delay_reg   <= delay_ok_reg ? WORD_W'(elapsed_reg * rrbb_pkg::DELAY_SCALE) : '0;
        end
        if (state_reg == ST_LOSS) begin
            frac_reg <= '0;
        end
        if ((state_reg == ST_DIV) && div_status.done) begin
            frac_reg <= div_quot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.report_ssrc     <= item_reg.source_ssrc;
            m_data_reg.fraction_lost   <= frac_reg;
            m_data_reg.cumulative_lost <= cum_reg;
            m_data_reg.cycles_out      <= item_reg.seq_cycles;
            m_data_reg.highest_seq_out <= item_reg.highest_seq;
            m_data_reg.jitter_out      <= item_reg.jitter_raw[WORD_W-1:WORD_W-rrbb_pkg::JIT_W];
            m_data_reg.last_sr_out     <= item_reg.last_sr_stamp;
            m_data_reg.sr_delay        <= delay_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // divider only reports back while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // divider only iterates while the sequencer waits for it
    a_div_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    // a skipped source leaves the block idle and gives no result
    a_skip_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.skip_source && !m_valid_reg) |=> (s_ready && !m_valid_reg))
        else $error("skipped source disturbed the block");

    // no expected packets in the interval means zero loss fraction
    a_zero_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_LOSS) && (exp_int_reg == '0)) |=> (frac_reg == '0))
        else $error("nonzero fraction with empty interval");

    // a finished block reaches the output register when it is free
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=> (m_valid && s_ready))
        else $error("report block not loaded");

endmodule
